/* hdl/mtbp_pkg.sv */
// ----------------------------------------------------------------------------
// mtbp_pkg
// Types and constants shared by the threshold 1bpp packer modules.
// ----------------------------------------------------------------------------
package mtbp_pkg;

  localparam int unsigned COMP_W    = 8;   // one colour component
  localparam int unsigned LEVEL_W   = 9;   // black level register
  localparam int unsigned WBITS_W   = 6;   // word length register
  localparam int unsigned WORD_W    = 32;  // packed output word
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 9;
  localparam int unsigned LUMA_W    = 13;  // 32 * 255 fits in 13 bits

  // luma weights, sum of weights is 32
  localparam logic [3:0] W_RED   = 4'd11;
  localparam logic [4:0] W_GREEN = 5'd16;
  localparam logic [2:0] W_BLUE  = 3'd5;
  localparam int unsigned LUMA_SHIFT = 5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLACK_LEVEL = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_BITS   = 8'd1;

  localparam logic [LEVEL_W-1:0] BLACK_LEVEL_RST = 9'd128;
  localparam logic [WBITS_W-1:0] WORD_BITS_RST   = 6'd8;

  typedef struct packed {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
    logic              row_end;
  } pix_t;

  typedef struct packed {
    logic black;
    logic row_end;
  } bit_t;

endpackage

/* hdl/mono_threshold_bit_packer.sv */
// ----------------------------------------------------------------------------
// mono_threshold_bit_packer
// Threshold RGB pixels to one bit each and pack them MSB-first into words.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_ready_o) moves one pixel and a row end flag
// per transfer. Each pixel with luma (11r + 16g + 5b) / 32 below the black
// level becomes a 1 bit. After word_bits pixels, or at a row end, the word is
// offered on the output channel (out_valid_o / out_ready_i), partial words
// zero-padded in their low bits.
// A pixel that closes a word passes the input register and then the output
// word register before its word shows at out_valid_o.
// Throughput: one pixel per cycle unless stalled, set by the input and output
// word registers, with only the luma sum and bit insert between them.
// Configuration writes (cfg_valid_i / cfg_ready_o) are always taken; index 0
// is black_level, index 1 is word_bits. Write only while no pixel is in flight.
// Reset clears the pixel count, the accumulator and both valid flags and loads
// black_level 128 and word_bits 8.
// When the receiver stalls, the word is held; pixels that do not close a word
// are still taken, and one closing a word waits in the input register.
// ----------------------------------------------------------------------------
module mono_threshold_bit_packer #(
  parameter int unsigned MAX_WORD_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mtbp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mtbp_pkg::CFG_DAT_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [mtbp_pkg::COMP_W-1:0]     red_i,
  input  logic [mtbp_pkg::COMP_W-1:0]     green_i,
  input  logic [mtbp_pkg::COMP_W-1:0]     blue_i,
  input  logic                            row_end_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [mtbp_pkg::WORD_W-1:0]     packed_word_o
);
  import mtbp_pkg::*;

  logic [LEVEL_W-1:0] black_level_q, black_level_d;
  logic [WBITS_W-1:0] word_bits_q, word_bits_d;

  pix_t pix_in, pix_s1;
  bit_t pix_bit;
  logic s1_valid;
  logic advance;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    black_level_d = black_level_q;
    word_bits_d   = word_bits_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_BLACK_LEVEL: black_level_d = cfg_data_i[LEVEL_W-1:0];
        CFG_WORD_BITS:   word_bits_d   = cfg_data_i[WBITS_W-1:0];
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      black_level_q <= BLACK_LEVEL_RST;
      word_bits_q   <= WORD_BITS_RST;
    end else begin
      black_level_q <= black_level_d;
      word_bits_q   <= word_bits_d;
    end
  end

  assign pix_in = '{red: red_i, green: green_i, blue: blue_i, row_end: row_end_i};

  mtbp_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .pix_i      (pix_in),
    .advance_i  (advance),
    .valid_o    (s1_valid),
    .pix_o      (pix_s1)
  );

  mtbp_luma u_luma (
    .pix_i         (pix_s1),
    .black_level_i (black_level_q),
    .bit_o         (pix_bit)
  );

  mtbp_pack #(
    .MAX_WORD_BITS (MAX_WORD_BITS)
  ) u_pack (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (s1_valid),
    .bit_i         (pix_bit),
    .word_bits_i   (word_bits_q),
    .advance_o     (advance),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .packed_word_o (packed_word_o)
  );

endmodule

/* hdl/mtbp_in_stage.sv */
// ----------------------------------------------------------------------------
// mtbp_in_stage
// Input register: holds one pixel until the packer takes it.
// ----------------------------------------------------------------------------
module mtbp_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mtbp_pkg::pix_t pix_i,
  input  logic          advance_i,
  output logic          valid_o,
  output mtbp_pkg::pix_t pix_o
);
  import mtbp_pkg::*;

  logic valid_q, valid_d;
  pix_t pix_q;

  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      pix_q <= pix_i;
    end
  end

  assign valid_o = valid_q;
  assign pix_o   = pix_q;

endmodule

/* hdl/mtbp_luma.sv */
// ----------------------------------------------------------------------------
// mtbp_luma
// Weighted luma of one pixel and compare against the black level.
// ----------------------------------------------------------------------------
module mtbp_luma (
  input  mtbp_pkg::pix_t                pix_i,
  input  logic [mtbp_pkg::LEVEL_W-1:0]  black_level_i,
  output mtbp_pkg::bit_t                bit_o
);
  import mtbp_pkg::*;

  logic [LUMA_W-1:0] sum;
  logic [COMP_W-1:0] gray;

  always_comb begin
    sum = LUMA_W'(W_RED) * LUMA_W'(pix_i.red)
        + LUMA_W'(W_GREEN) * LUMA_W'(pix_i.green)
        + LUMA_W'(W_BLUE) * LUMA_W'(pix_i.blue);
    gray = sum[LUMA_W-1:LUMA_SHIFT];
    bit_o.black   = {1'b0, gray} < black_level_i;
    bit_o.row_end = pix_i.row_end;
  end

endmodule

/* hdl/mtbp_pack.sv */
// ----------------------------------------------------------------------------
// mtbp_pack
// Bit accumulator, pixel count and output word register.
// ----------------------------------------------------------------------------
module mtbp_pack #(
  parameter int unsigned MAX_WORD_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  mtbp_pkg::bit_t                bit_i,
  input  logic [mtbp_pkg::WBITS_W-1:0]  word_bits_i,
  output logic                          advance_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mtbp_pkg::WORD_W-1:0]   packed_word_o
);
  import mtbp_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WORD_BITS);      // stored count, index
  localparam int unsigned LW = $clog2(MAX_WORD_BITS + 1);  // length, count + 1
  localparam logic [WBITS_W:0] MAX_LEN = (WBITS_W+1)'(MAX_WORD_BITS);

  logic [MAX_WORD_BITS-1:0] accum_q, accum_d, accum_set;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic                     out_valid_q, out_valid_d;
  logic [WORD_W-1:0]        word_q, word_next;

  logic [LW-1:0]            len;
  logic [LW-1:0]            cnt_inc;
  logic [CW-1:0]            pos;
  logic                     set_bit;
  logic                     emit;
  logic                     out_free;

  // effective length: zero acts as one, clamp to the accumulator size
  always_comb begin
    priority if (word_bits_i == '0) begin
      len = LW'(1);
    end else if ({1'b0, word_bits_i} > MAX_LEN) begin
      len = LW'(MAX_LEN);
    end else begin
      len = LW'({1'b0, word_bits_i});
    end
  end

  always_comb begin
    cnt_inc   = LW'(cnt_q) + LW'(1);
    set_bit   = bit_i.black && (LW'(cnt_q) < len);
    pos       = CW'(len - cnt_inc);
    accum_set = accum_q;
    if (set_bit) begin
      accum_set = accum_q | ({{(MAX_WORD_BITS-1){1'b0}}, 1'b1} << pos);
    end
    emit      = (cnt_inc >= len) || bit_i.row_end;
    out_free  = !out_valid_q || out_ready_i;
    advance_o = valid_i && (!emit || out_free);
  end

  generate
    if (MAX_WORD_BITS >= WORD_W) begin : g_trunc
      assign word_next = accum_set[WORD_W-1:0];
    end else begin : g_ext
      assign word_next = {{(WORD_W-MAX_WORD_BITS){1'b0}}, accum_set};
    end
  endgenerate

  always_comb begin
    accum_d     = accum_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (advance_o) begin
      if (emit) begin
        accum_d     = '0;
        cnt_d       = '0;
        out_valid_d = 1'b1;
      end else begin
        accum_d = accum_set;
        cnt_d   = cnt_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      accum_q     <= accum_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // hold the word while the receiver stalls
  always_ff @(posedge clk_i) begin
    if (advance_o && emit) begin
      word_q <= word_next;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign packed_word_o = word_q;

endmodule

/* hdl/mtbp_checker.sv */
// ----------------------------------------------------------------------------
// mtbp_checker
// Port-level checks for the threshold packer, bound to the top level.
// ----------------------------------------------------------------------------
module mtbp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_ready_o,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [mtbp_pkg::WORD_W-1:0]   packed_word_o
);
  import mtbp_pkg::*;

  // a stalled word stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  // and does not change
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(packed_word_o))
    else $error("output word changed while stalled");

  // with the output side free, the input side never holds back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o || out_ready_i |-> in_ready_o)
    else $error("input stalled although output is free");

  // nothing is offered straight out of reset
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o && cfg_ready_o)
    else $error("output valid or config stall after reset");

endmodule

bind mono_threshold_bit_packer mtbp_checker u_mtbp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_ready_o   (cfg_ready_o),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .packed_word_o (packed_word_o)
);
